/* design/tapsc_pkg.sv */
package tapsc_pkg;

  // Operand and accumulator widths of the shared multiply-accumulate unit.
  localparam int MAC_A_W = 24;
  localparam int MAC_B_W = 20;
  localparam int PROD_W  = MAC_A_W + MAC_B_W;
  localparam int ACC_W   = 64;

  // Filter coefficient tables, signed Q3.20. Taps past the fourth are zero.
  localparam int MAX_TAPS  = 8;
  localparam int TAP_IDX_W = 3;

  localparam logic signed [MAC_A_W-1:0] COEF_B [MAX_TAPS] = '{
    24'sd3039, 24'sd9117, 24'sd9117, 24'sd3039,
    24'sd0, 24'sd0, 24'sd0, 24'sd0
  };

  localparam logic signed [MAC_A_W-1:0] COEF_A [MAX_TAPS] = '{
    -24'sd2489419, 24'sd2023076, -24'sd557921, 24'sd0,
    24'sd0, 24'sd0, 24'sd0, 24'sd0
  };

  // Register indexes of the configuration port, one word per register.
  localparam logic [2:0] REG_SETPOINT_X   = 3'd0;
  localparam logic [2:0] REG_SETPOINT_Y   = 3'd1;
  localparam logic [2:0] REG_PROP_GAIN_X  = 3'd2;
  localparam logic [2:0] REG_DERIV_GAIN_X = 3'd3;
  localparam logic [2:0] REG_PROP_GAIN_Y  = 3'd4;
  localparam logic [2:0] REG_DERIV_GAIN_Y = 3'd5;

  // Alignment of a product before it enters the accumulator.
  typedef logic [1:0] shift_t;
  localparam shift_t SH_NONE = 2'd0;
  localparam shift_t SH_18   = 2'd1;
  localparam shift_t SH_20   = 2'd2;

  typedef struct packed {
    logic   clear;
    logic   issue;
    logic   accum;
    logic   neg;
    shift_t shift;
  } mac_ctrl_t;

  localparam logic signed [ACC_W-1:0] S36_MAX = 64'sd34359738367;
  localparam logic signed [ACC_W-1:0] S36_MIN = -64'sd34359738368;

  function automatic logic signed [35:0] sat36(input logic signed [ACC_W-1:0] v);
    logic signed [35:0] r;
    if (v > S36_MAX) begin
      r = 36'sh7FFFFFFFF;
    end else if (v < S36_MIN) begin
      r = 36'sh800000000;
    end else begin
      r = v[35:0];
    end
    return r;
  endfunction

endpackage

/* design/tapsc_mac.sv */
module tapsc_mac import tapsc_pkg::*; (
  input  logic                      clk,
  input  mac_ctrl_t                 ctrl,
  input  logic signed [MAC_A_W-1:0] op_a,
  input  logic signed [MAC_B_W-1:0] op_b,
  output logic signed [ACC_W-1:0]   acc
);

  logic signed [PROD_W-1:0] prod;
  logic                     prod_neg;
  shift_t                   prod_shift;
  logic signed [ACC_W-1:0]  term;

  // The product is registered; the accumulator adds the aligned and signed term from that register.
  always_comb begin
    term = ACC_W'(prod);
    case (prod_shift)
      SH_NONE: term = ACC_W'(prod);
      SH_18:   term = ACC_W'(prod) <<< 18;
      SH_20:   term = ACC_W'(prod) <<< 20;
      default: term = ACC_W'(prod);
    endcase
    if (prod_neg) begin
      term = -term;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.issue) begin
      prod       <= op_a * op_b;
      prod_neg   <= ctrl.neg;
      prod_shift <= ctrl.shift;
    end
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.accum) begin
      acc <= acc + term;
    end
  end

endmodule

/* design/two_axis_iir_pd_servo_controller.sv */
// Two-axis ball-balancing servo controller. Each input transfer carries one raw
// touch position sample per axis. For each axis, the sample goes through a fixed
// third-order IIR low-pass filter (signed Q3.20 coefficients, outputs kept in
// Q15.20 and saturated to 36 bits). The filtered position is subtracted from the
// axis setpoint, and the error and its change since the previous item are weighted
// by the proportional and derivative gains. The resulting force is turned into a
// tilt angle, clamped to 10..170 degrees, and into a servo PWM compare value.
// One output transfer follows every input transfer. All arithmetic runs through a
// single shared multiply-accumulate unit driven by a small sequencer, x axis first
// and then y axis; every product goes through a multiply state and then an
// accumulate state. The input side is not ready while an item is being
// worked on. The result sits in an output register, so a new item is taken while
// the previous result still waits; the block only stalls at the very end of an
// item if the previous result has still not been taken. Configuration registers
// sit at byte addresses 4*i in the order setpoint_x, setpoint_y, prop_gain_x,
// deriv_gain_x, prop_gain_y, deriv_gain_y, and should only be written while no
// item is in flight.
module two_axis_iir_pd_servo_controller import tapsc_pkg::*; #(
  parameter int TAPS        = 4,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                      clk,
  input  logic                                      rst,
  // Input stream.
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // Fields from bit 0: x_sample, y_sample, zero padding to whole bytes.
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]        s_tdata,
  // Output stream.
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // Fields from bit 0: x_compare[11:0], y_compare[11:0], x_angle[7:0], y_angle[7:0].
  output logic [39:0]                               m_tdata,
  // Configuration port.
  input  logic                                      psel,
  input  logic                                      penable,
  input  logic                                      pwrite,
  input  logic [4:0]                                paddr,
  input  logic [31:0]                               pwdata,
  output logic [31:0]                               prdata,
  output logic                                      pready
);

  // Filter terms per axis: TAPS feed-forward products, and two half products
  // for each of the TAPS-1 feedback taps (the 36-bit history is split in two).
  localparam int NF = 3*TAPS - 2;
  localparam int IW = $clog2(NF);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_ACC  = 4'd2;
  localparam logic [3:0] S_FRND = 4'd3;
  localparam logic [3:0] S_ERR  = 4'd4;
  localparam logic [3:0] S_DIF  = 4'd5;
  localparam logic [3:0] S_PSTO = 4'd6;
  localparam logic [3:0] S_DSTO = 4'd7;
  localparam logic [3:0] S_TSUM = 4'd8;
  localparam logic [3:0] S_ULIM = 4'd9;
  localparam logic [3:0] S_DEG  = 4'd10;
  localparam logic [3:0] S_CMP  = 4'd11;

  localparam logic [2:0] PH_FILT = 3'd0;
  localparam logic [2:0] PH_PROP = 3'd1;
  localparam logic [2:0] PH_DERV = 3'd2;
  localparam logic [2:0] PH_QUOT = 3'd3;
  localparam logic [2:0] PH_THRD = 3'd4;

  // 90 degrees expressed in the scaled domain: 9000 * 2^20.
  localparam logic signed [46:0] T_OFFSET = 47'sd9437184000;
  // Largest scaled value that still matters: 170 degrees times 100.
  localparam logic [14:0] U_LIMIT = 15'd17000;
  // Reciprocals for the divisions by 100 and by 3.
  localparam logic signed [MAC_A_W-1:0] RECIP_100 = 24'sd5243;
  localparam logic signed [MAC_A_W-1:0] RECIP_3   = 24'sd683;
  localparam logic [7:0]  ANGLE_MIN   = 8'd10;
  localparam logic [11:0] CMP_BASE    = 12'd3820;

  // Configuration registers.
  logic [12:0] setpoint_x;
  logic [12:0] setpoint_y;
  logic [15:0] prop_gain_x;
  logic [19:0] deriv_gain_x;
  logic [15:0] prop_gain_y;
  logic [19:0] deriv_gain_y;

  // Sequencer.
  logic [3:0]    state;
  logic [2:0]    phase;
  logic [IW-1:0] idx;
  logic          axis;

  // Per-axis filter and derivative history.
  logic [SAMPLE_BITS-1:0] hin      [2][TAPS];
  logic signed [35:0]     hout     [2][TAPS-1];
  logic signed [35:0]     last_err [2];

  // Working registers of the axis being computed.
  logic signed [35:0] filt;
  logic signed [35:0] err;
  logic signed [36:0] dlt;
  logic signed [41:0] force_q;
  logic signed [46:0] tsum;
  logic [14:0]        uclip;
  logic [7:0]         deg;
  logic [11:0]        res_xc;
  logic [7:0]         res_xa;

  // Output register.
  logic        out_valid;
  logic        out_load;
  logic [11:0] out_xc;
  logic [11:0] out_yc;
  logic [7:0]  out_xa;
  logic [7:0]  out_ya;

  // Shared multiply-accumulate unit.
  mac_ctrl_t                 mac_ctrl;
  logic signed [MAC_A_W-1:0] op_a;
  logic signed [MAC_B_W-1:0] op_b;
  logic signed [ACC_W-1:0]   acc;
  logic                      term_neg;
  shift_t                    term_shift;

  logic                   cfg_write;
  logic [2:0]             cfg_idx;
  logic                   in_xfer;
  logic [IW-1:0]          fj;
  logic [TAP_IDX_W-1:0]   ftap;
  logic                   fhi;
  logic                   ffwd;
  logic [SAMPLE_BITS-1:0] hin_sel;
  logic signed [35:0]     hout_sel;
  logic [12:0]            sp_sel;
  logic [15:0]            kp_sel;
  logic [19:0]            kd_sel;
  logic                   last_term;
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-1:0] sp_diff;
  logic [7:0]             quot;
  logic [11:0]            cmp_val;

  assign pready    = 1'b1;
  assign cfg_idx   = paddr[4:2];
  assign cfg_write = psel & penable & pwrite & pready;

  always_comb begin
    case (cfg_idx)
      REG_SETPOINT_X:   prdata = 32'(setpoint_x);
      REG_SETPOINT_Y:   prdata = 32'(setpoint_y);
      REG_PROP_GAIN_X:  prdata = 32'(prop_gain_x);
      REG_DERIV_GAIN_X: prdata = 32'(deriv_gain_x);
      REG_PROP_GAIN_Y:  prdata = 32'(prop_gain_y);
      REG_DERIV_GAIN_Y: prdata = 32'(deriv_gain_y);
      default:          prdata = '0;
    endcase
  end

  assign s_tready = (state == S_IDLE);
  assign in_xfer  = s_tvalid & s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = {out_ya, out_xa, out_yc, out_xc};

  // The finished y axis moves both results into the output register once it is
  // free or being emptied in the same cycle.
  assign out_load = (state == S_CMP) & axis & (~out_valid | m_tready);

  assign sp_sel = axis ? setpoint_y   : setpoint_x;
  assign kp_sel = axis ? prop_gain_y  : prop_gain_x;
  assign kd_sel = axis ? deriv_gain_y : deriv_gain_x;

  // Filter term decode: feed-forward terms first, then the feedback taps as
  // a low half and a high half each.
  always_comb begin
    ffwd = (idx < IW'(TAPS));
    fj   = idx - IW'(TAPS);
    if (ffwd) begin
      ftap = TAP_IDX_W'(idx);
      fhi  = 1'b0;
    end else begin
      ftap = TAP_IDX_W'(fj >> 1);
      fhi  = fj[0];
    end
    hin_sel  = '0;
    hout_sel = '0;
    for (int k = 0; k < TAPS; k++) begin
      if (ftap == TAP_IDX_W'(k)) begin
        hin_sel = hin[axis][k];
      end
    end
    for (int k = 0; k < TAPS - 1; k++) begin
      if (ftap == TAP_IDX_W'(k)) begin
        hout_sel = hout[axis][k];
      end
    end
  end

  // Operand selection for the shared unit.
  always_comb begin
    op_a       = '0;
    op_b       = '0;
    term_neg   = 1'b0;
    term_shift = SH_NONE;
    case (phase)
      PH_FILT: begin
        if (ffwd) begin
          op_a       = COEF_B[ftap];
          op_b       = MAC_B_W'(hin_sel);
          term_shift = SH_20;
        end else begin
          op_a     = COEF_A[ftap];
          term_neg = 1'b1;
          if (fhi) begin
            op_b       = MAC_B_W'(signed'(hout_sel[35:18]));
            term_shift = SH_18;
          end else begin
            op_b = MAC_B_W'(hout_sel[17:0]);
          end
        end
      end
      PH_PROP: begin
        op_a = MAC_A_W'(kp_sel);
        if (idx[0]) begin
          op_b       = MAC_B_W'(signed'(err[35:18]));
          term_shift = SH_18;
        end else begin
          op_b = MAC_B_W'(err[17:0]);
        end
      end
      PH_DERV: begin
        op_a = MAC_A_W'(kd_sel);
        if (idx[0]) begin
          op_b       = MAC_B_W'(signed'(dlt[36:18]));
          term_shift = SH_18;
        end else begin
          op_b = MAC_B_W'(dlt[17:0]);
        end
      end
      PH_QUOT: begin
        op_a = RECIP_100;
        op_b = MAC_B_W'(uclip);
      end
      PH_THRD: begin
        op_a = RECIP_3;
        op_b = MAC_B_W'({deg, 2'b00});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    case (phase)
      PH_FILT: last_term = (idx == IW'(NF - 1));
      PH_PROP: last_term = idx[0];
      PH_DERV: last_term = idx[0];
      default: last_term = 1'b1;
    endcase
  end

  // The accumulator keeps the compare product while the y result waits for the
  // output register; in S_CMP it is cleared only when the x axis hands over to the y axis.
  always_comb begin
    mac_ctrl.clear = (state inside {S_IDLE, S_DIF, S_PSTO, S_ULIM, S_DEG}) ||
                     ((state == S_CMP) && !axis);
    mac_ctrl.issue = (state == S_MUL);
    mac_ctrl.accum = (state == S_ACC);
    mac_ctrl.neg   = term_neg;
    mac_ctrl.shift = term_shift;
  end

  tapsc_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .op_a (op_a),
    .op_b (op_b),
    .acc  (acc)
  );

  // Datapath helpers for the single-step states.
  assign rnd     = acc + 64'sd524288;
  assign sp_diff = signed'({31'b0, sp_sel, 20'b0}) - ACC_W'(filt);
  assign quot    = acc[26:19];
  assign cmp_val = CMP_BASE - {4'b0, acc[18:11]};

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint_x   <= 13'd5000;
      setpoint_y   <= 13'd3340;
      prop_gain_x  <= 16'd4260;
      deriv_gain_x <= 20'd65536;
      prop_gain_y  <= 16'd4260;
      deriv_gain_y <= 20'd78643;
      state        <= S_IDLE;
      phase        <= PH_FILT;
      idx          <= '0;
      axis         <= 1'b0;
      out_valid    <= 1'b0;
      for (int a = 0; a < 2; a++) begin
        for (int k = 0; k < TAPS; k++) begin
          hin[a][k] <= '0;
        end
        for (int k = 0; k < TAPS - 1; k++) begin
          hout[a][k] <= '0;
        end
        last_err[a] <= '0;
      end
    end else begin
      if (cfg_write) begin
        case (cfg_idx)
          REG_SETPOINT_X:   setpoint_x   <= pwdata[12:0];
          REG_SETPOINT_Y:   setpoint_y   <= pwdata[12:0];
          REG_PROP_GAIN_X:  prop_gain_x  <= pwdata[15:0];
          REG_DERIV_GAIN_X: deriv_gain_x <= pwdata[19:0];
          REG_PROP_GAIN_Y:  prop_gain_y  <= pwdata[15:0];
          REG_DERIV_GAIN_Y: deriv_gain_y <= pwdata[19:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            // Both input histories take their new sample up front.
            for (int k = TAPS - 1; k > 0; k--) begin
              hin[0][k] <= hin[0][k-1];
              hin[1][k] <= hin[1][k-1];
            end
            hin[0][0] <= s_tdata[SAMPLE_BITS-1:0];
            hin[1][0] <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            axis  <= 1'b0;
            phase <= PH_FILT;
            idx   <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          if (last_term) begin
            case (phase)
              PH_FILT: state <= S_FRND;
              PH_PROP: state <= S_PSTO;
              PH_DERV: state <= S_DSTO;
              PH_QUOT: state <= S_DEG;
              PH_THRD: state <= S_CMP;
              default: state <= S_IDLE;
            endcase
          end else begin
            idx   <= idx + 1'b1;
            state <= S_MUL;
          end
        end
        S_FRND: begin
          // Round the Q40 sum to Q20 and saturate.
          filt  <= sat36(rnd >>> 20);
          state <= S_ERR;
        end
        S_ERR: begin
          err <= sat36(sp_diff);
          for (int k = TAPS - 2; k > 0; k--) begin
            hout[axis][k] <= hout[axis][k-1];
          end
          hout[axis][0] <= filt;
          state <= S_DIF;
        end
        S_DIF: begin
          dlt            <= 37'(err) - 37'(last_err[axis]);
          last_err[axis] <= err;
          phase          <= PH_PROP;
          idx            <= '0;
          state          <= S_MUL;
        end
        S_PSTO: begin
          force_q <= 42'(acc >>> 16);
          phase   <= PH_DERV;
          idx     <= '0;
          state   <= S_MUL;
        end
        S_DSTO: begin
          force_q <= force_q + 42'(acc >>> 16);
          state   <= S_TSUM;
        end
        S_TSUM: begin
          // Scaled angle: force * 9 + 90 degrees, in units of 2^-20 / 100 degree.
          tsum  <= (47'(force_q) <<< 3) + 47'(force_q) + T_OFFSET;
          state <= S_ULIM;
        end
        S_ULIM: begin
          // Negative values truncate to angles at or below zero and clamp low;
          // anything past 170 degrees clamps high.
          if (tsum[46]) begin
            uclip <= '0;
          end else if (tsum[45:20] >= 26'(U_LIMIT)) begin
            uclip <= U_LIMIT;
          end else begin
            uclip <= tsum[34:20];
          end
          phase <= PH_QUOT;
          idx   <= '0;
          state <= S_MUL;
        end
        S_DEG: begin
          deg   <= (quot < ANGLE_MIN) ? ANGLE_MIN : quot;
          phase <= PH_THRD;
          idx   <= '0;
          state <= S_MUL;
        end
        S_CMP: begin
          if (!axis) begin
            res_xc <= cmp_val;
            res_xa <= deg;
            axis   <= 1'b1;
            phase  <= PH_FILT;
            idx    <= '0;
            state  <= S_MUL;
          end else if (out_load) begin
            out_xc <= res_xc;
            out_xa <= res_xa;
            out_yc <= cmp_val;
            out_ya <= deg;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* test/two_axis_iir_pd_servo_controller_tb.sv */
module two_axis_iir_pd_servo_controller_tb;
  import tapsc_pkg::*;

  // Unused register slots of the configuration port.
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  // One servo command as it travels on m_tdata, x_compare in the lowest bits.
  typedef struct packed {
    logic [7:0]  y_angle;
    logic [7:0]  x_angle;
    logic [11:0] y_compare;
    logic [11:0] x_compare;
  } servo_cmd_t;

  localparam int     AXIS_X          = 0;
  localparam int     AXIS_Y          = 1;
  localparam int     HOLD_CYCLES     = 600;
  localparam int     ITEMS_PER_PHASE = 300;
  localparam int     SETTLE_CYCLES   = 100;
  localparam longint ONE_Q20         = 64'sd1 << 20;
  localparam longint MAX36           = 64'sd34359738367;
  localparam longint MIN36           = -64'sd34359738368;

  // Low-pass coefficients in signed Q3.20: feed-forward taps, then feedback taps.
  localparam longint LP_FF [4] = '{64'sd3039, 64'sd9117, 64'sd9117, 64'sd3039};
  localparam longint LP_FB [3] = '{-64'sd2489419, 64'sd2023076, -64'sd557921};

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // Fields from bit 0: x_sample[11:0], y_sample[11:0].
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // Fields from bit 0: x_compare, y_compare, x_angle, y_angle.
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  two_axis_iir_pd_servo_controller uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Shadow copy of the controller: configuration and per-axis filter state.
  longint setpoint [2];
  longint prop_gain [2];
  longint deriv_gain [2];
  longint raw_hist [2][4];
  longint smooth_hist [2][3];
  longint prev_error [2];

  // Servo commands predicted for accepted samples, oldest first.
  servo_cmd_t pending_cmds [$];
  int         mismatch_count;

  // When calm is set neither side idles. hold_off_req asks the receiver to refuse
  // output transfers until hold_count reaches HOLD_CYCLES; the receiver clears it.
  bit calm;
  bit hold_off_req;
  int hold_count;

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic longint clip36(input longint v);
    if (v > MAX36) begin
      return MAX36;
    end
    if (v < MIN36) begin
      return MIN36;
    end
    return v;
  endfunction

  task automatic reset_shadow();
    setpoint   = '{64'd5000, 64'd3340};
    prop_gain  = '{64'd4260, 64'd4260};
    deriv_gain = '{64'd65536, 64'd78643};
    for (int a = 0; a < 2; a++) begin
      for (int i = 0; i < 4; i++) begin
        raw_hist[a][i] = 0;
      end
      for (int i = 0; i < 3; i++) begin
        smooth_hist[a][i] = 0;
      end
      prev_error[a] = 0;
    end
  endtask

  // Mirror of a register write; bits above each register's width are dropped
  // and the spare addresses change nothing.
  task automatic shadow_register(input int idx, input logic [31:0] value);
    case (idx)
      REG_SETPOINT_X:   setpoint[AXIS_X]   = longint'(value[12:0]);
      REG_SETPOINT_Y:   setpoint[AXIS_Y]   = longint'(value[12:0]);
      REG_PROP_GAIN_X:  prop_gain[AXIS_X]  = longint'(value[15:0]);
      REG_DERIV_GAIN_X: deriv_gain[AXIS_X] = longint'(value[19:0]);
      REG_PROP_GAIN_Y:  prop_gain[AXIS_Y]  = longint'(value[15:0]);
      REG_DERIV_GAIN_Y: deriv_gain[AXIS_Y] = longint'(value[19:0]);
      default: ;
    endcase
  endtask

  // Runs one axis through the low-pass filter and the PD law, updating its
  // history, and returns the clamped angle and the servo compare value.
  task automatic servo_axis(input int ax, input logic [11:0] sample,
                            output logic [7:0] angle, output logic [11:0] compare);
    longint acc;
    longint filtered;
    longint err;
    longint derr;
    longint drive_q;
    longint deg;
    for (int i = 3; i > 0; i--) begin
      raw_hist[ax][i] = raw_hist[ax][i-1];
    end
    raw_hist[ax][0] = longint'(sample);
    acc = 0;
    for (int i = 0; i < 4; i++) begin
      acc += LP_FF[i] * raw_hist[ax][i] * ONE_Q20;
    end
    for (int i = 0; i < 3; i++) begin
      acc -= LP_FB[i] * smooth_hist[ax][i];
    end
    // Round to Q20 by adding half and taking the floor.
    filtered = clip36((acc + (ONE_Q20 >>> 1)) >>> 20);
    for (int i = 2; i > 0; i--) begin
      smooth_hist[ax][i] = smooth_hist[ax][i-1];
    end
    smooth_hist[ax][0] = filtered;

    err = clip36(setpoint[ax] * ONE_Q20 - filtered);
    derr = err - prev_error[ax];
    prev_error[ax] = err;
    drive_q = ((err * prop_gain[ax]) >>> 16) + ((derr * deriv_gain[ax]) >>> 16);

    // force*180/2000 + 90, truncated toward zero, then clamped.
    deg = (drive_q * 9 + 64'sd9000 * ONE_Q20) / (64'sd100 * ONE_Q20);
    if (deg > 170) begin
      deg = 170;
    end
    if (deg < 10) begin
      deg = 10;
    end
    angle = 8'(deg);
    compare = 12'(64'sd4000 - (deg * 4) / 3 - 64'sd180);
  endtask

  task automatic predict_command(input logic [11:0] xs, input logic [11:0] ys);
    servo_cmd_t cmd;
    servo_axis(AXIS_X, xs, cmd.x_angle, cmd.x_compare);
    servo_axis(AXIS_Y, ys, cmd.y_angle, cmd.y_compare);
    pending_cmds.push_back(cmd);
  endtask

  // Offers one sample pair and returns once the transfer has been accepted.
  // Valid is only lowered when the sender decides to idle before this item.
  task automatic send_sample(input logic [11:0] xs, input logic [11:0] ys);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 17) begin
      s_tvalid = 1'b0;
      s_tdata = 24'($urandom);
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {ys, xs};
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    predict_command(xs, ys);
  endtask

  // Stops offering samples and waits for every predicted command to arrive.
  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_cmds.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic apb_write(input int idx, input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = 5'(idx * 4);
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    shadow_register(idx, value);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic write_all(input logic [31:0] spx, input logic [31:0] spy,
                           input logic [31:0] kpx, input logic [31:0] kdx,
                           input logic [31:0] kpy, input logic [31:0] kdy);
    apb_write(REG_SETPOINT_X, spx);
    apb_write(REG_SETPOINT_Y, spy);
    apb_write(REG_PROP_GAIN_X, kpx);
    apb_write(REG_DERIV_GAIN_X, kdx);
    apb_write(REG_PROP_GAIN_Y, kpy);
    apb_write(REG_DERIV_GAIN_Y, kdy);
  endtask

  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // The receiver idles at random unless calm, and holds off completely while a
  // hold-off has been requested, counting the cycles itself.
  always @(negedge clk) begin
    if (hold_off_req) begin
      m_tready = 1'b0;
      hold_count++;
      if (hold_count >= HOLD_CYCLES) begin
        hold_count = 0;
        hold_off_req = 1'b0;
      end
    end else begin
      m_tready = calm || ($urandom_range(0, 99) >= 17);
    end
  end

  // Every output transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    servo_cmd_t got;
    servo_cmd_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = servo_cmd_t'(m_tdata);
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected output transfer, expected none, actual %h",
                 $time, m_tdata);
        mismatch_count++;
      end else begin
        want = pending_cmds.pop_front();
        report_field("x_compare", want.x_compare, got.x_compare);
        report_field("y_compare", want.y_compare, got.y_compare);
        report_field("x_angle", want.x_angle, got.x_angle);
        report_field("y_angle", want.y_angle, got.y_angle);
      end
    end
  end

  // Reset configuration: corner samples and bit patterns, then held steps so the
  // filter and the derivative term see both settling and sudden change. The
  // very first item checks that the derivative starts from a zero error.
  task automatic test_reset_config();
    send_sample(12'd0, 12'd0);
    send_sample(12'hFFF, 12'hFFF);
    send_sample(12'hFFF, 12'd0);
    send_sample(12'd0, 12'hFFF);
    send_sample(12'hAAA, 12'h555);
    send_sample(12'h555, 12'hAAA);
    repeat (3) send_sample(12'hFFF, 12'hFFF);
    repeat (3) send_sample(12'd0, 12'd0);
    drain();
  endtask

  // Registers written with every bit set, so the bits above each width must be
  // dropped; setpoint_y ends up zero through its upper bits only. The spare
  // addresses are written too and must have no effect. Full gains drive the
  // angle into both clamps, and zero gains hold it at the midpoint.
  task automatic test_register_extremes();
    write_all(32'hFFFF_FFFF, 32'hFFFF_E000, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    apb_write(REG_SPARE_6, 32'd0);
    apb_write(REG_SPARE_7, 32'hFFFF_FFFF);
    repeat (4) send_sample(12'd0, 12'hFFF);
    send_sample(12'hFFF, 12'd0);
    repeat (2) send_sample(12'd0, 12'hFFF);
    drain();
    write_all(32'd0, 32'd8191, 32'd0, 32'd0, 32'd0, 32'd0);
    repeat (3) send_sample(12'hFFF, 12'd0);
    drain();
  endtask

  // Several configurations in turn: reset values, all zero, all maximum (with
  // neither side idling), and random ones. Samples mostly follow a moving ball:
  // slow random walks and held steps, with bursts of pure noise in between.
  task automatic test_random_phases();
    int pos [2];
    int n;
    int mode;
    int run_len;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_all(32'd5000, 32'd3340, 32'd4260, 32'd65536, 32'd4260, 32'd78643);
        1: write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        2: write_all(32'd8191, 32'd8191, 32'd65535, 32'hFFFFF, 32'd65535, 32'hFFFFF);
        default: begin
          write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
      endcase
      calm = (phase == 2);
      pos = '{2048, 2048};
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        mode = $urandom_range(0, 9);
        run_len = $urandom_range(4, 40);
        for (int k = 0; k < run_len; k++) begin
          for (int a = 0; a < 2; a++) begin
            if (mode < 6) begin
              pos[a] = pos[a] + $urandom_range(0, 200) - 100;
              if (pos[a] < 0) begin
                pos[a] = 0;
              end
              if (pos[a] > 4095) begin
                pos[a] = 4095;
              end
            end else if (mode < 8) begin
              if (k == 0) begin
                pos[a] = $urandom_range(0, 4095);
              end
            end else begin
              pos[a] = $urandom_range(0, 4095);
            end
          end
          send_sample(12'(pos[AXIS_X]), 12'(pos[AXIS_Y]));
          n++;
        end
      end
      drain();
      calm = 1'b0;
    end
  endtask

  // The receiver refuses results for a long stretch while samples keep coming,
  // so the output register fills and the input side has to stall.
  task automatic test_output_backpressure();
    write_all(32'd2048, 32'd2048, 32'd20000, 32'd100000, 32'd20000, 32'd100000);
    @(negedge clk);
    hold_off_req = 1'b1;
    for (int i = 0; i < 8; i++) begin
      send_sample(12'($urandom), 12'($urandom));
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    calm = 1'b0;
    hold_off_req = 1'b0;
    hold_count = 0;
    mismatch_count = 0;
    reset_shadow();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_config();
    test_register_extremes();
    test_random_phases();
    test_output_backpressure();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_cmds.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
